>>> design/pth_pkg.sv
// Shared types, sizes and codes of the page translation hash table.
// Used by pth_bucket_ram, pth_way_logic and page_translation_hash_table.
package pth_pkg;

   localparam int BUCKETS  = 1024;
   localparam int WAYS     = 4;
   localparam int BUCKET_W = $clog2(BUCKETS);
   localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

   localparam int REQ_W    = 2;
   localparam int FILE_W   = 16;
   localparam int OFFSET_W = 48;
   localparam int ADDR_W   = 52;
   localparam int STATUS_W = 2;

   localparam logic [REQ_W-1:0] REQ_LOOKUP = REQ_W'(0);
   localparam logic [REQ_W-1:0] REQ_PUT    = REQ_W'(1);
   localparam logic [REQ_W-1:0] REQ_INVAL  = REQ_W'(2);
   localparam logic [REQ_W-1:0] REQ_UNUSED = REQ_W'(3);

   localparam logic [STATUS_W-1:0] STATUS_DONE = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] STATUS_NULL = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] STATUS_FULL = STATUS_W'(2);

   typedef struct packed {
      logic                valid;
      logic [FILE_W-1:0]   file;
      logic [OFFSET_W-1:0] offset;
      logic [ADDR_W-1:0]   frame;
   } entry_type;

   typedef entry_type [WAYS-1:0] row_type;

   typedef struct packed {
      logic                wr_en;
      logic                hit;
      logic [ADDR_W-1:0]   found_addr;
      logic [STATUS_W-1:0] status;
   } way_result_type;

endpackage

>>> design/page_translation_hash_table.sv
// Top level of the page translation hash table: control sequencer and result register.
// Uses pth_pkg, pth_bucket_ram and pth_way_logic.
//
// A request beat is taken when start is high and busy is low. It carries
// req_type (lookup, put, invalidate file), req_file_id, req_page_offset and
// req_phys_addr. Every request gives exactly one result beat, shown on
// rsp_hit, rsp_found_addr and rsp_status for one cycle while rsp_strobe is high.
// The receiver cannot stall; a result is never held.
// A lookup or a put reads one bucket row, compares all ways, and writes the
// row back in the next cycle when a put changes it. The result is registered
// from the compare, and busy drops in the same cycle that it appears, so a new
// request is taken only once the last result is shown. A null file takes this path too.
// An invalidate of a non-null file sweeps every bucket row, one per cycle,
// through the one read port and the one write port of the bucket memory.
// After reset, busy stays high while a clearing pass writes every row of
// the memory empty.
module page_translation_hash_table (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [pth_pkg::REQ_W-1:0]    req_type,
   input  logic [pth_pkg::FILE_W-1:0]   req_file_id,
   input  logic [pth_pkg::OFFSET_W-1:0] req_page_offset,
   input  logic [pth_pkg::ADDR_W-1:0]   req_phys_addr,
   output logic                         rsp_strobe,
   output logic                         rsp_hit,
   output logic [pth_pkg::ADDR_W-1:0]   rsp_found_addr,
   output logic [pth_pkg::STATUS_W-1:0] rsp_status
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_SWEEP
   } state_type;

   state_type                      state_ff;
   logic [pth_pkg::BUCKET_W-1:0]   ptr_ff;
   logic [pth_pkg::REQ_W-1:0]      type_ff;
   logic [pth_pkg::FILE_W-1:0]     file_ff;
   logic [pth_pkg::OFFSET_W-1:0]   offset_ff;
   logic [pth_pkg::ADDR_W-1:0]     phys_ff;
   logic                           rsp_strobe_ff;
   logic                           rsp_hit_ff;
   logic [pth_pkg::ADDR_W-1:0]     rsp_found_addr_ff;
   logic [pth_pkg::STATUS_W-1:0]   rsp_status_ff;

   logic                           accept;
   logic [31:0]                    mixed;
   logic [pth_pkg::BUCKET_W-1:0]   req_bucket;
   logic [pth_pkg::BUCKET_W-1:0]   last_row;
   logic [pth_pkg::BUCKET_W-1:0]   rd_addr;
   logic                           wr_en;
   pth_pkg::row_type               wr_data;
   pth_pkg::row_type               rd_data;
   pth_pkg::row_type               new_row;
   pth_pkg::way_result_type        result;
   logic                           sweep;

   assign accept     = start && (state_ff == ST_IDLE);
   assign busy       = (state_ff != ST_IDLE);
   assign mixed      = {16'b0, req_file_id} ^ req_page_offset[31:0];
   assign req_bucket = pth_pkg::BUCKET_W'(mixed % pth_pkg::BUCKETS);
   assign last_row   = pth_pkg::BUCKET_W'(pth_pkg::BUCKETS - 1);
   assign sweep      = (state_ff == ST_SWEEP);

   always_comb begin
      rd_addr = ptr_ff + pth_pkg::BUCKET_W'(1);
      wr_en   = 1'b0;
      wr_data = new_row;
      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = (req_type == pth_pkg::REQ_INVAL) ? '0 : req_bucket;
         end
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = '0;
         end
         ST_LOOK, ST_SWEEP: begin
            wr_en = result.wr_en;
         end
         default: begin
         end
      endcase
   end

   pth_bucket_ram u_ram (
      .clock      (clock),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (ptr_ff),
      .wr_data    (wr_data)
   );

   pth_way_logic u_way (
      .row         (rd_data),
      .sweep       (sweep),
      .req_type    (type_ff),
      .file_id     (file_ff),
      .page_offset (offset_ff),
      .phys_addr   (phys_ff),
      .new_row     (new_row),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         ptr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               ptr_ff <= ptr_ff + pth_pkg::BUCKET_W'(1);
               if (ptr_ff == last_row) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  type_ff   <= req_type;
                  file_ff   <= req_file_id;
                  offset_ff <= req_page_offset;
                  phys_ff   <= req_phys_addr;
                  if (req_type == pth_pkg::REQ_INVAL && req_file_id != '0) begin
                     ptr_ff   <= '0;
                     state_ff <= ST_SWEEP;
                  end else begin
                     ptr_ff   <= req_bucket;
                     state_ff <= ST_LOOK;
                  end
               end
            end
            ST_LOOK: begin
               rsp_strobe_ff     <= 1'b1;
               rsp_hit_ff        <= result.hit;
               rsp_found_addr_ff <= result.found_addr;
               rsp_status_ff     <= result.status;
               state_ff          <= ST_IDLE;
            end
            ST_SWEEP: begin
               ptr_ff <= ptr_ff + pth_pkg::BUCKET_W'(1);
               if (ptr_ff == last_row) begin
                  rsp_strobe_ff     <= 1'b1;
                  rsp_hit_ff        <= 1'b0;
                  rsp_found_addr_ff <= '0;
                  rsp_status_ff     <= pth_pkg::STATUS_DONE;
                  state_ff          <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_found_addr = rsp_found_addr_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

>>> design/pth_bucket_ram.sv
// Bucket memory: one row holds all ways of one bucket.
// Synchronous write, registered read; uses pth_pkg.
module pth_bucket_ram (
   input  logic                         clock,
   input  logic [pth_pkg::BUCKET_W-1:0] rd_addr,
   output pth_pkg::row_type             rd_data_ff,
   input  logic                         wr_en,
   input  logic [pth_pkg::BUCKET_W-1:0] wr_addr,
   input  pth_pkg::row_type             wr_data
);

   pth_pkg::row_type mem [pth_pkg::BUCKETS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

>>> design/pth_way_logic.sv
// Way compare and row update for one bucket: lookup, put and invalidate.
// Purely combinational; uses pth_pkg.
module pth_way_logic (
   input  pth_pkg::row_type               row,
   input  logic                           sweep,
   input  logic [pth_pkg::REQ_W-1:0]      req_type,
   input  logic [pth_pkg::FILE_W-1:0]     file_id,
   input  logic [pth_pkg::OFFSET_W-1:0]   page_offset,
   input  logic [pth_pkg::ADDR_W-1:0]     phys_addr,
   output pth_pkg::row_type               new_row,
   output pth_pkg::way_result_type        result
);

   logic                      hit_found;
   logic [pth_pkg::WAY_W-1:0] hit_way;
   logic                      free_found;
   logic [pth_pkg::WAY_W-1:0] free_way;

   always_comb begin
      hit_found  = 1'b0;
      hit_way    = '0;
      free_found = 1'b0;
      free_way   = '0;
      for (int w = 0; w < pth_pkg::WAYS; w++) begin
         if (!hit_found && row[w].valid && row[w].file == file_id &&
             row[w].offset == page_offset) begin
            hit_found = 1'b1;
            hit_way   = pth_pkg::WAY_W'(w);
         end
         if (!free_found && !row[w].valid) begin
            free_found = 1'b1;
            free_way   = pth_pkg::WAY_W'(w);
         end
      end
   end

   always_comb begin
      new_row           = row;
      result.wr_en      = 1'b0;
      result.hit        = 1'b0;
      result.found_addr = '0;
      result.status     = pth_pkg::STATUS_DONE;
      if (sweep) begin
         result.wr_en = 1'b1;
         for (int w = 0; w < pth_pkg::WAYS; w++) begin
            if (row[w].valid && row[w].file == file_id) begin
               new_row[w].valid = 1'b0;
            end
         end
      end else if (file_id == '0) begin
         result.status = pth_pkg::STATUS_NULL;
      end else begin
         unique case (req_type)
            pth_pkg::REQ_LOOKUP: begin
               result.hit = hit_found;
               if (hit_found) begin
                  result.found_addr = row[hit_way].frame;
               end
            end
            pth_pkg::REQ_PUT: begin
               if (hit_found) begin
                  result.hit             = 1'b1;
                  result.wr_en           = 1'b1;
                  new_row[hit_way].frame = phys_addr;
               end else if (free_found) begin
                  result.wr_en             = 1'b1;
                  new_row[free_way].valid  = 1'b1;
                  new_row[free_way].file   = file_id;
                  new_row[free_way].offset = page_offset;
                  new_row[free_way].frame  = phys_addr;
               end else begin
                  result.status = pth_pkg::STATUS_FULL;
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule

>>> bench/page_translation_hash_table_tb.sv
// Testbench for page_translation_hash_table: directed and random lookups, puts and invalidates.
// Each result beat is checked against an in-bench model of the bucketed table.
// Depends on pth_pkg and the page_translation_hash_table design files.
module page_translation_hash_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRIES     = pth_pkg::BUCKETS * pth_pkg::WAYS;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOT_COUNT   = 4;
   localparam int FILE_COUNT  = 8;
   localparam int POOL_DEPTH  = 64;

   typedef struct packed {
      logic [pth_pkg::FILE_W-1:0]   file;
      logic [pth_pkg::OFFSET_W-1:0] offset;
   } page_key_type;

   typedef struct packed {
      logic                         hit;
      logic [pth_pkg::ADDR_W-1:0]   addr;
      logic [pth_pkg::STATUS_W-1:0] status;
   } xlat_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [pth_pkg::REQ_W-1:0]    req_type = pth_pkg::REQ_LOOKUP;
   logic [pth_pkg::FILE_W-1:0]   req_file_id = '0;
   logic [pth_pkg::OFFSET_W-1:0] req_page_offset = '0;
   logic [pth_pkg::ADDR_W-1:0]   req_phys_addr = '0;
   logic                         rsp_strobe;
   logic                         rsp_hit;
   logic [pth_pkg::ADDR_W-1:0]   rsp_found_addr;
   logic [pth_pkg::STATUS_W-1:0] rsp_status;

   bit                           table_valid [ENTRIES];
   logic [pth_pkg::FILE_W-1:0]   table_file [ENTRIES];
   logic [pth_pkg::OFFSET_W-1:0] table_offset [ENTRIES];
   logic [pth_pkg::ADDR_W-1:0]   table_frame [ENTRIES];

   xlat_result_type              expected_xlat [$];
   page_key_type                 key_pool [$];
   int unsigned                  hot_bucket [HOT_COUNT];
   logic [pth_pkg::FILE_W-1:0]   file_set [FILE_COUNT];
   int unsigned                  errors = 0;
   int unsigned                  cycle_count = 0;
   bit                           steady = 1'b0;

   page_translation_hash_table u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_file_id     (req_file_id),
      .req_page_offset (req_page_offset),
      .req_phys_addr   (req_phys_addr),
      .rsp_strobe      (rsp_strobe),
      .rsp_hit         (rsp_hit),
      .rsp_found_addr  (rsp_found_addr),
      .rsp_status      (rsp_status)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic xlat_result_type predict_translation(
         logic [pth_pkg::REQ_W-1:0] kind, logic [pth_pkg::FILE_W-1:0] file,
         logic [pth_pkg::OFFSET_W-1:0] off, logic [pth_pkg::ADDR_W-1:0] phys);
      xlat_result_type r;
      logic [31:0]     mixed;
      int              base;
      int              w;
      int              free_way;
      bit              found;
      r = '0;
      r.status = pth_pkg::STATUS_DONE;
      mixed = 32'(file) ^ off[31:0];
      base = int'(mixed % 32'(pth_pkg::BUCKETS)) * pth_pkg::WAYS;
      found = 1'b0;
      free_way = -1;
      if (file == '0) begin
         r.status = pth_pkg::STATUS_NULL;
      end else if (kind == pth_pkg::REQ_LOOKUP) begin
         for (w = 0; w < pth_pkg::WAYS && !found; w++) begin
            if (table_valid[base + w] && table_file[base + w] == file &&
                table_offset[base + w] == off) begin
               found = 1'b1;
               r.hit = 1'b1;
               r.addr = table_frame[base + w];
            end
         end
      end else if (kind == pth_pkg::REQ_PUT) begin
         for (w = 0; w < pth_pkg::WAYS && !found; w++) begin
            if (table_valid[base + w] && table_file[base + w] == file &&
                table_offset[base + w] == off) begin
               found = 1'b1;
               r.hit = 1'b1;
               table_frame[base + w] = phys;
            end else if (free_way < 0 && !table_valid[base + w]) begin
               free_way = w;
            end
         end
         if (!found) begin
            if (free_way >= 0) begin
               table_valid[base + free_way] = 1'b1;
               table_file[base + free_way] = file;
               table_offset[base + free_way] = off;
               table_frame[base + free_way] = phys;
            end else begin
               r.status = pth_pkg::STATUS_FULL;
            end
         end
      end else if (kind == pth_pkg::REQ_INVAL) begin
         for (w = 0; w < ENTRIES; w++) begin
            if (table_valid[w] && table_file[w] == file) table_valid[w] = 1'b0;
         end
      end
      return r;
   endfunction

   function automatic logic [pth_pkg::OFFSET_W-1:0] random_offset();
      return pth_pkg::OFFSET_W'({$urandom(), $urandom()});
   endfunction

   function automatic logic [pth_pkg::ADDR_W-1:0] random_frame();
      return pth_pkg::ADDR_W'({$urandom(), $urandom()});
   endfunction

   function automatic logic [pth_pkg::OFFSET_W-1:0] offset_for_bucket(
         logic [pth_pkg::FILE_W-1:0] file, int unsigned bucket,
         logic [pth_pkg::OFFSET_W-1:0] upper);
      logic [pth_pkg::OFFSET_W-1:0] off;
      off = upper;
      off[pth_pkg::BUCKET_W-1:0] = pth_pkg::BUCKET_W'(bucket) ^ file[pth_pkg::BUCKET_W-1:0];
      return off;
   endfunction

   function automatic page_key_type crowded_key(int k);
      page_key_type key;
      key.file = (k < 2) ? 16'h1234 : 16'h4321;
      key.offset = offset_for_bucket(key.file, 5, {16'(k + 1), 32'h0});
      return key;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      if ($urandom_range(0, 49) == 0) steady = !steady;
      r = $urandom_range(0, 99);
      if (steady || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   always @(negedge clock) begin : check_results
      xlat_result_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (expected_xlat.size() == 0) begin
            $error("result beat with no request outstanding");
            errors++;
         end else begin
            want = expected_xlat.pop_front();
            if (rsp_hit !== want.hit) begin
               $error("rsp_hit: expected %0d, got %0d", want.hit, rsp_hit);
               errors++;
            end
            if (rsp_found_addr !== want.addr) begin
               $error("rsp_found_addr: expected %h, got %h", want.addr, rsp_found_addr);
               errors++;
            end
            if (rsp_status !== want.status) begin
               $error("rsp_status: expected %0d, got %0d", want.status, rsp_status);
               errors++;
            end
         end
      end
   end

   // Called at a rising edge; returns at a rising edge with start left high when no gap follows.
   task automatic send_request(input logic [pth_pkg::REQ_W-1:0] kind,
         input logic [pth_pkg::FILE_W-1:0] file, input logic [pth_pkg::OFFSET_W-1:0] off,
         input logic [pth_pkg::ADDR_W-1:0] phys);
      int unsigned gap;
      start <= 1'b1;
      req_type <= kind;
      req_file_id <= file;
      req_page_offset <= off;
      req_phys_addr <= phys;
      do @(negedge clock); while (busy !== 1'b0);
      expected_xlat.push_back(predict_translation(kind, file, off, phys));
      @(posedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic test_null_file();
      send_request(pth_pkg::REQ_LOOKUP, '0, random_offset(), random_frame());
      send_request(pth_pkg::REQ_PUT, '0, random_offset(), random_frame());
      send_request(pth_pkg::REQ_INVAL, '0, random_offset(), random_frame());
      send_request(pth_pkg::REQ_UNUSED, '0, random_offset(), random_frame());
   endtask

   task automatic test_field_extremes();
      send_request(pth_pkg::REQ_PUT, '1, '1, '1);
      send_request(pth_pkg::REQ_LOOKUP, '1, '1, '0);
      send_request(pth_pkg::REQ_LOOKUP, '1, {1'b0, {(pth_pkg::OFFSET_W - 1){1'b1}}}, '0);
      send_request(pth_pkg::REQ_PUT, 16'h0001, '0, '0);
      send_request(pth_pkg::REQ_LOOKUP, 16'h0001, '0, '1);
   endtask

   task automatic test_bucket_full();
      page_key_type key;
      int           k;
      for (k = 0; k < pth_pkg::WAYS + 1; k++) begin
         key = crowded_key(k);
         send_request(pth_pkg::REQ_PUT, key.file, key.offset, random_frame());
      end
      key = crowded_key(pth_pkg::WAYS);
      send_request(pth_pkg::REQ_LOOKUP, key.file, key.offset, '0);
   endtask

   task automatic test_update();
      page_key_type key;
      key = crowded_key(0);
      send_request(pth_pkg::REQ_PUT, key.file, key.offset, random_frame());
      send_request(pth_pkg::REQ_LOOKUP, key.file, key.offset, '0);
   endtask

   task automatic test_invalidate();
      page_key_type key;
      send_request(pth_pkg::REQ_INVAL, 16'h1234, random_offset(), random_frame());
      key = crowded_key(0);
      send_request(pth_pkg::REQ_LOOKUP, key.file, key.offset, '0);
      key = crowded_key(pth_pkg::WAYS);
      send_request(pth_pkg::REQ_PUT, key.file, key.offset, random_frame());
      send_request(pth_pkg::REQ_LOOKUP, key.file, key.offset, '0);
      send_request(pth_pkg::REQ_INVAL, 16'h7777, '0, '0);
   endtask

   task automatic test_unused_code();
      page_key_type key;
      key = crowded_key(2);
      send_request(pth_pkg::REQ_UNUSED, key.file, key.offset, random_frame());
      send_request(pth_pkg::REQ_LOOKUP, key.file, key.offset, '0);
   endtask

   function automatic page_key_type fresh_key();
      page_key_type key;
      if ($urandom_range(0, 9) < 7) key.file = file_set[$urandom_range(0, FILE_COUNT - 1)];
      else key.file = pth_pkg::FILE_W'($urandom_range(1, 65535));
      if ($urandom_range(0, 1) == 0)
         key.offset = offset_for_bucket(key.file,
                                        hot_bucket[$urandom_range(0, HOT_COUNT - 1)],
                                        random_offset());
      else
         key.offset = random_offset();
      return key;
   endfunction

   function automatic page_key_type pool_key();
      if (key_pool.size() == 0) return fresh_key();
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
   endfunction

   // Mostly puts and lookups on a small set of files crowding a few buckets,
   // so hits, updates, full buckets and wide invalidates all happen often.
   task automatic test_random(input int count);
      page_key_type key;
      int unsigned  r;
      int           n;
      for (n = 0; n < HOT_COUNT; n++) hot_bucket[n] = $urandom_range(0, pth_pkg::BUCKETS - 1);
      for (n = 0; n < FILE_COUNT; n++) file_set[n] = pth_pkg::FILE_W'($urandom_range(1, 65535));
      for (n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 5) begin
            send_request(pth_pkg::REQ_W'($urandom_range(0, 3)), '0, random_offset(),
                         random_frame());
         end else if (r < 8) begin
            key = pool_key();
            send_request(pth_pkg::REQ_UNUSED, key.file, key.offset, random_frame());
         end else if (r < 11) begin
            key = ($urandom_range(0, 4) != 0) ? pool_key() : fresh_key();
            send_request(pth_pkg::REQ_INVAL, key.file, random_offset(), random_frame());
         end else if (r < 45) begin
            if ($urandom_range(0, 9) < 4) begin
               key = pool_key();
            end else begin
               key = fresh_key();
               key_pool.push_back(key);
               if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
            end
            send_request(pth_pkg::REQ_PUT, key.file, key.offset, random_frame());
         end else if (r < 85) begin
            key = ($urandom_range(0, 9) < 7) ? pool_key() : fresh_key();
            send_request(pth_pkg::REQ_LOOKUP, key.file, key.offset, random_frame());
         end else begin
            key = pool_key();
            if ($urandom_range(0, 3) == 0)
               key.file[$urandom_range(0, pth_pkg::FILE_W - 1)] ^= 1'b1;
            else
               key.offset[$urandom_range(0, pth_pkg::OFFSET_W - 1)] ^= 1'b1;
            send_request(pth_pkg::REQ_LOOKUP, key.file, key.offset, random_frame());
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_null_file();
      test_field_extremes();
      test_bucket_full();
      test_update();
      test_invalidate();
      test_unused_code();
      test_random(1250);
      start <= 1'b0;
      while (expected_xlat.size() != 0) @(posedge clock);
      repeat (pth_pkg::BUCKETS + 64) @(posedge clock);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> files.f
design/pth_pkg.sv
design/pth_bucket_ram.sv
design/pth_way_logic.sv
design/page_translation_hash_table.sv
bench/page_translation_hash_table_tb.sv
